// ===== sv/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    localparam int WORD_BITS = 32;
    localparam int DIV_W     = 33;   // byte count plus rounding term
    localparam int ADDR_W    = 24;
    localparam int TOTAL_W   = 13;

    // block size is a power of two
    localparam int BLOCK_SHIFT = 12;
    localparam int BLOCK_BYTES = 1 << BLOCK_SHIFT;

    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;
    localparam logic [TOTAL_W-1:0]   TOTAL_RESET = 13'd4096;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESERVE = 2'd2,
        OP_INIT    = 2'd3
    } bba_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_SIZE,
        ST_DIV_OFS,
        ST_CHECK,
        ST_SCAN_RD,
        ST_SCAN,
        ST_MK_SET,
        ST_MK_RD,
        ST_MK_WR,
        ST_DONE
    } bba_state_t;

endpackage

`default_nettype wire

// ===== sv/bba_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Block count from a byte count: the block size is a power of two, so the
// quotient is a shift, ready the cycle after start.
module bba_div
    import bba_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    logic [DIV_W-1:0] quo_reg;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            quo_reg <= dividend >> BLOCK_SHIFT;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== sv/bitmap_block_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// First-fit block allocator over a used-block bitmap (1 = used), 32 blocks per word.
// Request channel: operation, offset_bytes, size_bytes are taken at a clock edge with
// start high and busy low. busy stays high until the result has been shown.
// Result channel: done is high for exactly one cycle with ok and address_bytes valid;
// the receiver cannot stall, it must take the result in that cycle.
// total_blocks is written through total_blocks_we / total_blocks_wdata while idle;
// the user must keep to this, the block itself does not enforce it.
// Allocate fails when the size is zero or too large; otherwise it scans the map
// and, on success, marks the blocks found, read-modify-write per word touched.
// Free and reserve clear or set the blocks of their range, word by word;
// initialize sweeps the map clear and then reserves blocks from block 0.
// One request at a time: the next one is taken in the cycle after done.
// Byte counts become block counts by a shift (BLOCK_BYTES is a power of two); the
// scan tests 8 blocks per cycle from the registered map read; marking is
// read-modify-write on the map memory.
// After reset the map is swept clear, one word a cycle, with busy high.
module bitmap_block_allocator_top
    import bba_pkg::*;
#(
    parameter int BLOCK_CAPACITY = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         operation,
    input  wire logic [31:0]        offset_bytes,
    input  wire logic [31:0]        size_bytes,
    input  wire logic               total_blocks_we,
    input  wire logic [TOTAL_W-1:0] total_blocks_wdata,
    output logic                    done,
    output logic                    ok,
    output logic [ADDR_W-1:0]       address_bytes
);

    localparam int MAP_WORDS = (BLOCK_CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BLK_W     = WAW + 6;      // block index or count, up to MAP_WORDS*32
    localparam int LAST_WORD = MAP_WORDS - 1;

    // state
    bba_state_t         state_reg, state_next;
    bba_op_t            op_reg, op_next;
    logic [31:0]        offset_reg, offset_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [DIV_W-1:0]   need_reg, need_next;
    logic [DIV_W-1:0]   first_reg, first_next;
    logic [BLK_W-1:0]   end_reg, end_next;
    logic [WAW-1:0]     word_reg, word_next;
    logic [1:0]         byte_reg, byte_next;
    logic [BLK_W-1:0]   run_reg, run_next;
    logic [BLK_W-1:0]   start_reg, start_next;
    logic               ok_reg, ok_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;

    // map memory
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] map_rdata_reg;
    logic                 rd_en, wr_en;
    logic [WAW-1:0]       rd_addr, wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // byte to block conversion
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_dividend, div_quotient;

    // combinational helpers
    logic [BLK_W-1:0]     lim_b;
    logic [BLK_W-1:0]     need_b;
    logic                 need_ok;
    logic [7:0]           byte_bits;
    logic                 scan_found, scan_stop, scan_last;
    logic [BLK_W-1:0]     scan_run, scan_start;
    logic [DIV_W:0]       mk_sum, mk_lim, mk_end;
    logic                 mk_empty;
    logic [BLK_W-1:0]     last_b;
    logic [WAW-1:0]       first_w, last_w;
    logic [4:0]           mk_lo, mk_hi;
    logic [WORD_BITS-1:0] mk_mask;
    logic                 mk_set;
    logic                 accept;

    assign accept = start && (state_reg == ST_IDLE);

    // managed blocks = min(total_blocks, BLOCK_CAPACITY)
    assign lim_b = ({19'b0, total_reg} > 32'(BLOCK_CAPACITY)) ? BLK_W'(BLOCK_CAPACITY)
                                                              : BLK_W'(total_reg);
    assign need_b  = need_reg[BLK_W-1:0];
    assign need_ok = (need_reg != '0) && (need_reg <= DIV_W'(lim_b));
    assign mk_set  = (op_reg != OP_FREE);

    bba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Divider feed: rounded size (or rounded total for init) at accept,
    // plain offset for the second pass of free and reserve.
    always_comb
    begin
        div_start = accept ||
                    ((state_reg == ST_DIV_SIZE) && div_done &&
                     ((op_reg == OP_FREE) || (op_reg == OP_RESERVE)));
        if (state_reg == ST_IDLE)
        begin
            if (bba_op_t'(operation) == OP_INIT)
                div_dividend = {20'b0, total_reg} + DIV_W'(BLOCK_BYTES - 1);
            else
                div_dividend = {1'b0, size_bytes} + DIV_W'(BLOCK_BYTES - 1);
        end
        else
        begin
            div_dividend = {1'b0, offset_reg};
        end
    end

    // Scan 8 blocks of the current word; run length carries across bytes and words.
    assign byte_bits = map_rdata_reg[{byte_reg, 3'b000} +: 8];
    assign scan_last = (byte_reg == 2'd3) && (word_reg == WAW'(LAST_WORD));

    always_comb
    begin
        logic [BLK_W-1:0] blk;
        scan_run   = run_reg;
        scan_start = start_reg;
        scan_found = 1'b0;
        scan_stop  = 1'b0;
        for (int j = 0; j < 8; j++)
        begin
            blk = BLK_W'({word_reg, byte_reg, 3'(j)});
            if (!scan_found && !scan_stop)
            begin
                if (blk >= lim_b)
                begin
                    scan_stop = 1'b1;
                end
                else if (byte_bits[j])
                begin
                    scan_run = '0;
                end
                else
                begin
                    if (scan_run == '0)
                        scan_start = blk;
                    scan_run = scan_run + 1'b1;
                    if (scan_run >= need_b)
                        scan_found = 1'b1;
                end
            end
        end
    end

    // Range clip: end = min(first + count, managed blocks)
    assign mk_sum   = {1'b0, first_reg} + {1'b0, need_reg};
    assign mk_lim   = (DIV_W + 1)'(lim_b);
    assign mk_end   = (mk_sum > mk_lim) ? mk_lim : mk_sum;
    assign mk_empty = ({1'b0, first_reg} >= mk_end);

    // Per-word mask for the marked range
    assign last_b  = end_reg - 1'b1;
    assign first_w = first_reg[WAW+4:5];
    assign last_w  = last_b[WAW+4:5];
    assign mk_lo   = (word_reg == first_w) ? first_reg[4:0] : 5'd0;
    assign mk_hi   = (word_reg == last_w) ? last_b[4:0] : 5'd31;
    assign mk_mask = (FULL_WORD << mk_lo) & (FULL_WORD >> (5'd31 - mk_hi));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (word_reg == WAW'(LAST_WORD))
                    state_next = (op_reg == OP_INIT) ? ST_MK_SET : ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_DIV_SIZE;
            end
            ST_DIV_SIZE:
            begin
                if (div_done)
                begin
                    case (op_reg)
                        OP_ALLOC: state_next = ST_CHECK;
                        OP_INIT:  state_next = ST_CLEAR;
                        default:  state_next = ST_DIV_OFS;
                    endcase
                end
            end
            ST_DIV_OFS:
            begin
                if (div_done)
                    state_next = ST_MK_SET;
            end
            ST_CHECK:   state_next = need_ok ? ST_SCAN_RD : ST_DONE;
            ST_SCAN_RD: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_found)
                    state_next = ST_MK_SET;
                else if (scan_stop || scan_last)
                    state_next = ST_DONE;
            end
            ST_MK_SET:  state_next = mk_empty ? ST_DONE : ST_MK_RD;
            ST_MK_RD:   state_next = ST_MK_WR;
            ST_MK_WR:
            begin
                if (word_reg == last_w)
                    state_next = ST_DONE;
                else
                    state_next = ST_MK_RD;
            end
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath registers
    always_comb
    begin
        op_next     = op_reg;
        offset_next = offset_reg;
        need_next   = need_reg;
        first_next  = first_reg;
        end_next    = end_reg;
        word_next   = word_reg;
        byte_next   = byte_reg;
        run_next    = run_reg;
        start_next  = start_reg;
        ok_next     = ok_reg;
        addr_next   = addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                word_next = word_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = bba_op_t'(operation);
                    offset_next = offset_bytes;
                    ok_next     = 1'b1;
                    addr_next   = '0;
                end
            end
            ST_DIV_SIZE:
            begin
                if (div_done)
                begin
                    need_next  = div_quotient;
                    first_next = '0;
                    word_next  = '0;
                end
            end
            ST_DIV_OFS:
            begin
                if (div_done)
                    first_next = div_quotient;
            end
            ST_CHECK:
            begin
                word_next  = '0;
                byte_next  = 2'd0;
                run_next   = '0;
                start_next = '0;
                if (!need_ok)
                    ok_next = 1'b0;
            end
            ST_SCAN:
            begin
                run_next   = scan_run;
                start_next = scan_start;
                if (scan_found)
                begin
                    first_next = DIV_W'(scan_start);
                end
                else if (scan_stop || scan_last)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    byte_next = byte_reg + 1'b1;
                    if (byte_reg == 2'd3)
                        word_next = word_reg + 1'b1;
                end
            end
            ST_MK_SET:
            begin
                end_next  = BLK_W'(mk_end);
                word_next = first_reg[WAW+4:5];
                if (op_reg == OP_ALLOC)
                    addr_next = ADDR_W'(32'(first_reg[BLK_W-1:0]) * 32'(BLOCK_BYTES));
            end
            ST_MK_WR:
            begin
                word_next = word_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = word_reg;
        wr_en   = 1'b0;
        wr_addr = word_reg;
        wr_data = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
            end
            ST_SCAN_RD:
            begin
                rd_en = 1'b1;
            end
            ST_SCAN:
            begin
                // fetch the next word while the last byte is tested
                rd_en   = (byte_reg == 2'd3) && !scan_found && !scan_stop && !scan_last;
                rd_addr = word_reg + 1'b1;
            end
            ST_MK_RD:
            begin
                rd_en = 1'b1;
            end
            ST_MK_WR:
            begin
                wr_en   = 1'b1;
                wr_data = mk_set ? (map_rdata_reg | mk_mask) : (map_rdata_reg & ~mk_mask);
            end
            default:
            begin
            end
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = (state_reg == ST_DONE);
    assign ok            = ok_reg;
    assign address_bytes = addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            op_reg    <= OP_ALLOC;
            word_reg  <= '0;
            byte_reg  <= 2'd0;
            total_reg <= TOTAL_RESET;
            ok_reg    <= 1'b0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            word_reg  <= word_next;
            byte_reg  <= byte_next;
            ok_reg    <= ok_next;
            addr_reg  <= addr_next;
            if (total_blocks_we)
                total_reg <= total_blocks_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        need_reg   <= need_next;
        first_reg  <= first_next;
        end_reg    <= end_next;
        run_reg    <= run_next;
        start_reg  <= start_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            map_mem[wr_addr] <= wr_data;
        if (rd_en)
            map_rdata_reg <= map_mem[rd_addr];
    end

endmodule

`default_nettype wire
